### rtl/core/mvpcm_pkg.sv
// ----------------------------------------------------------------------------
// mvpcm_pkg
// Shared types and constants of the multi-voice PCM sample player.
// ----------------------------------------------------------------------------
package mvpcm_pkg;

    localparam int VOICE_COUNT     = 16;
    localparam int VOICE_BITS      = 4;
    localparam int STORE_ADDR_BITS = 16;
    localparam int FRAC_BITS       = 12;

    localparam logic [31:0] BASE_OFFSET = 32'h0040_0000;
    localparam logic [9:0]  KEY_ADDR    = 10'h200;

    typedef enum logic [1:0] {
        CMD_REG_WRITE   = 2'd0,
        CMD_REG_READ    = 2'd1,
        CMD_STORE_WRITE = 2'd2,
        CMD_TICK        = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        CFG_STEP_SCALE = 3'd0,
        CFG_GAIN_ONE   = 3'd1,
        CFG_GAIN_TWO   = 3'd2,
        CFG_DIR_ONE    = 3'd3,
        CFG_DIR_TWO    = 3'd4
    } cfg_index_t;

    // Operations of the shared multiplier.
    typedef enum logic [1:0] {
        MUL_STEP = 2'd0,
        MUL_VOL  = 2'd1,
        MUL_GAIN = 2'd2
    } mul_op_t;

    // Request to the shared multiplier.
    typedef struct packed {
        logic                valid;
        mul_op_t             op;
        logic signed [24:0]  a;
        logic signed [17:0]  b;
    } mul_req_t;

    // Saturates a channel sum to 16 bits; route terms reach about 2^22,
    // so two of them plus the running mix need 26 bits.
    function automatic logic signed [15:0] sat16(input logic signed [25:0] v);
        if (v > 26'sd32767)
        begin
            return 16'sh7fff;
        end
        else if (v < -26'sd32768)
        begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

endpackage

### rtl/core/multi_voice_pcm_sample_player.sv
// ----------------------------------------------------------------------------
// multi_voice_pcm_sample_player
// Sixteen-voice PCM sample player and stereo mixer with a shared multiplier.
// ----------------------------------------------------------------------------
// After reset the block clears all 256 entries of the voice register file,
// with busy high. A register write, store write or key write is accepted
// without ever raising busy. A read keeps busy high through ST_RDREG and
// ST_RDOUT and returns its word with a one-cycle strobe in ST_RDOUT. A sample
// tick walks voices 0 to 15 one after another through a single multiplier
// and the register-file and sample-memory read ports: a voice that is not
// keyed is passed over in ST_VOICE, a keyed voice goes through ST_LDA, ST_LDB,
// ST_POS and, unless it reaches its end and is keyed off, the fetch, step,
// volume and gain states; ST_MIX presents the mix, which comes out as busy
// falls. The ST_LDA walk of its registers takes most of each keyed voice's time.
// The result cannot be stalled: it is on result_valid for exactly one cycle.
module multi_voice_pcm_sample_player
    import mvpcm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         command,
    input  logic [9:0]         address,
    input  logic [15:0]        data,
    input  logic [15:0]        rom_address,
    input  logic [7:0]         rom_data,
    output logic               result_valid,
    output logic [15:0]        read_data,
    output logic signed [15:0] left_sample,
    output logic signed [15:0] right_sample,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    typedef enum logic [14:0] {
        ST_IDLE  = 15'b000000000000001,
        ST_RDREG = 15'b000000000000010,
        ST_RDOUT = 15'b000000000000100,
        ST_VOICE = 15'b000000000001000,
        ST_LDA   = 15'b000000000010000,
        ST_LDB   = 15'b000000000100000,
        ST_POS   = 15'b000000001000000,
        ST_FETCH = 15'b000000010000000,
        ST_STEP  = 15'b000000100000000,
        ST_VOL1  = 15'b000001000000000,
        ST_GAIN1 = 15'b000010000000000,
        ST_VOL2  = 15'b000100000000000,
        ST_GAIN2 = 15'b001000000000000,
        ST_MIX   = 15'b010000000000000,
        ST_CLEAR = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [15:0] step_scale_reg, gain_one_reg, gain_two_reg;
    logic [1:0]  dir_one_reg, dir_two_reg;

    // Memories: voice register file, sample store, per-voice position.
    logic [15:0] vreg_mem [256];
    logic [7:0]  store_mem [2**STORE_ADDR_BITS];
    logic [31:0] pos_mem [VOICE_COUNT];
    logic [23:0] frac_mem [VOICE_COUNT];

    logic [15:0] key_reg;
    logic [VOICE_BITS-1:0] voice_reg;
    logic [3:0]  ridx_reg;
    logic [7:0]  clr_reg;
    logic [7:0]  raddr;
    logic [15:0] rdat_reg;
    logic [7:0]  sdat_reg;
    logic [15:0] rd_word_reg;
    logic        address_lt_reg;

    logic [15:0] r2, r3, r5, r6, r7, r9, r10, r11, r14, r15;
    logic [31:0] st_reg, en_reg, lp_reg, pos_reg;
    logic [23:0] frac_reg;
    logic signed [7:0]  s_reg;
    logic signed [23:0] t1_reg;
    logic signed [17:0] acc_l_reg, acc_r_reg;
    logic signed [15:0] left_reg, right_reg;
    logic        res_reg;
    logic [15:0] out_rd_reg;

    mul_req_t           mreq;
    logic               mdone;
    logic signed [42:0] mprod;
    logic signed [24:0] vfl;
    logic signed [23:0] tq;

    mvpcm_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mreq),
        .done    (mdone),
        .product (mprod)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_scale_reg <= 16'd4096;
            gain_one_reg   <= 16'd256;
            gain_two_reg   <= 16'd256;
            dir_one_reg    <= 2'd1;
            dir_two_reg    <= 2'd2;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_STEP_SCALE: step_scale_reg <= cfg_data;
                CFG_GAIN_ONE:   gain_one_reg   <= cfg_data;
                CFG_GAIN_TWO:   gain_two_reg   <= cfg_data;
                CFG_DIR_ONE:    dir_one_reg    <= cfg_data[1:0];
                CFG_DIR_TWO:    dir_two_reg    <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Register file read address: host address, else the current voice.
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            raddr = {address[8:5], address[4:1]};
        end
        else
        begin
            raddr = {voice_reg, ridx_reg};
        end
    end

    // Register file: one write port, one registered read port. The clearing
    // pass after reset zeroes one entry per cycle.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            vreg_mem[clr_reg] <= '0;
        end
        else if (state_reg == ST_IDLE && start && command == CMD_REG_WRITE
            && address < KEY_ADDR)
        begin
            vreg_mem[{address[8:5], address[4:1]}] <= data;
        end
        rdat_reg <= vreg_mem[raddr];
    end

    // Sample store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start && command == CMD_STORE_WRITE)
        begin
            store_mem[rom_address[STORE_ADDR_BITS-1:0]] <= rom_data;
        end
        sdat_reg <= store_mem[STORE_ADDR_BITS'((st_reg + pos_reg) ^ 32'd1)];
    end

    // Position storage, cleared on key-on, updated for each keyed voice in a tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VOICE_COUNT; i++)
            begin
                pos_mem[i]  <= '0;
                frac_mem[i] <= '0;
            end
        end
        else if (state_reg == ST_IDLE && start && command == CMD_REG_WRITE
                 && address == KEY_ADDR)
        begin
            for (int i = 0; i < VOICE_COUNT; i++)
            begin
                if (data[i] && !key_reg[i])
                begin
                    pos_mem[i]  <= '0;
                    frac_mem[i] <= '0;
                end
            end
        end
        else if ((state_reg == ST_POS && st_reg + pos_reg >= en_reg && r5 == 16'd0)
                 || (state_reg == ST_STEP && mdone))
        begin
            pos_mem[voice_reg]  <= pos_reg;
            frac_mem[voice_reg] <= (state_reg == ST_STEP)
                ? frac_reg + 24'(mprod >>> FRAC_BITS) : frac_reg;
        end
    end

    // Multiplier request and the two rounding steps of a route term.
    always_comb
    begin
        mreq       = '0;
        mreq.valid = 1'b0;
        mreq.op    = MUL_STEP;
        vfl        = 25'(mprod >>> 8);
        tq         = (mprod < 0) ? -24'(((-mprod) >>> 8)) : 24'(mprod >>> 8);
        case (state_reg)
            ST_FETCH:
            begin
                mreq.valid = 1'b1;
                mreq.op    = MUL_STEP;
                mreq.a     = 25'(r6);
                mreq.b     = 18'(step_scale_reg);
            end
            ST_STEP, ST_GAIN1:
            begin
                if (state_reg == ST_GAIN1 ? mdone : mdone)
                begin
                    mreq.valid = 1'b1;
                    mreq.op    = MUL_VOL;
                    // The sample byte is only in s_reg from the cycle after ST_STEP.
                    mreq.a     = (state_reg == ST_STEP) ? 25'(signed'(sdat_reg))
                                                        : 25'(s_reg);
                    mreq.b     = 18'(signed'(state_reg == ST_STEP ? r15 : r14));
                end
            end
            ST_VOL1, ST_VOL2:
            begin
                if (mdone)
                begin
                    mreq.valid = 1'b1;
                    mreq.op    = MUL_GAIN;
                    mreq.a     = vfl;
                    mreq.b     = 18'(state_reg == ST_VOL1 ? gain_one_reg : gain_two_reg);
                end
            end
            default: ;
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: state_next = (clr_reg == 8'hff) ? ST_IDLE : ST_CLEAR;
            ST_IDLE:
            begin
                if (start)
                begin
                    case (command)
                        CMD_REG_READ: state_next = ST_RDREG;
                        CMD_TICK:     state_next = ST_VOICE;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RDREG: state_next = ST_RDOUT;
            ST_RDOUT: state_next = ST_IDLE;
            ST_VOICE: state_next = key_reg[voice_reg] ? ST_LDA
                                 : (voice_reg == VOICE_BITS'(VOICE_COUNT-1) ? ST_MIX : ST_VOICE);
            ST_LDA:   state_next = (ridx_reg == 4'd15) ? ST_LDB : ST_LDA;
            ST_LDB:   state_next = ST_POS;
            ST_POS:   state_next = (st_reg + pos_reg >= en_reg && r5 == 16'd0)
                                 ? ((voice_reg == VOICE_BITS'(VOICE_COUNT-1)) ? ST_MIX : ST_VOICE)
                                 : ST_FETCH;
            ST_FETCH: state_next = ST_STEP;
            ST_STEP:  state_next = mdone ? ST_VOL1 : ST_STEP;
            ST_VOL1:  state_next = mdone ? ST_GAIN1 : ST_VOL1;
            ST_GAIN1: state_next = mdone ? ST_VOL2 : ST_GAIN1;
            ST_VOL2:  state_next = mdone ? ST_GAIN2 : ST_VOL2;
            ST_GAIN2: state_next = mdone
                                 ? ((voice_reg == VOICE_BITS'(VOICE_COUNT-1)) ? ST_MIX : ST_VOICE)
                                 : ST_GAIN2;
            ST_MIX:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            key_reg   <= '0;
            voice_reg <= '0;
            ridx_reg  <= '0;
            clr_reg   <= '0;
            res_reg   <= 1'b0;
            acc_l_reg <= '0;
            acc_r_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= 1'b0;
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                end
                ST_IDLE:
                begin
                    voice_reg <= '0;
                    ridx_reg  <= '0;
                    acc_l_reg <= '0;
                    acc_r_reg <= '0;
                    if (start && command == CMD_REG_WRITE && address == KEY_ADDR)
                    begin
                        key_reg <= data;
                    end
                    rd_word_reg <= (address == KEY_ADDR) ? key_reg : 16'd0;
                end
                ST_RDREG:
                begin
                    res_reg    <= 1'b1;
                    out_rd_reg <= (address_lt_reg) ? rdat_reg : rd_word_reg;
                    left_reg   <= '0;
                    right_reg  <= '0;
                end
                ST_VOICE:
                begin
                    ridx_reg <= '0;
                    if (!key_reg[voice_reg])
                    begin
                        voice_reg <= voice_reg + 1'b1;
                    end
                    else
                    begin
                        ridx_reg <= 4'd1;
                    end
                end
                ST_LDA:
                begin
                    ridx_reg <= ridx_reg + 1'b1;
                end
                ST_LDB:
                begin
                    st_reg   <= {r3, r2} - BASE_OFFSET;
                    en_reg   <= {r11, r10} - BASE_OFFSET;
                    lp_reg   <= {r9, r7} - BASE_OFFSET;
                    pos_reg  <= pos_mem[voice_reg] + 32'(frac_mem[voice_reg][23:FRAC_BITS]);
                    frac_reg <= {12'd0, frac_mem[voice_reg][FRAC_BITS-1:0]};
                end
                ST_POS:
                begin
                    if (st_reg + pos_reg >= en_reg)
                    begin
                        if (r5 != 16'd0)
                        begin
                            pos_reg <= lp_reg - st_reg;
                        end
                        else
                        begin
                            key_reg[voice_reg] <= 1'b0;
                            voice_reg <= voice_reg + 1'b1;
                        end
                    end
                end
                ST_STEP:
                begin
                    s_reg <= signed'(sdat_reg);
                end
                ST_GAIN1:
                begin
                    if (mdone)
                    begin
                        t1_reg <= tq;
                    end
                end
                ST_GAIN2:
                begin
                    if (mdone)
                    begin
                        acc_l_reg <= 18'(sat16(26'(acc_l_reg)
                            + (dir_one_reg[0] ? 26'(t1_reg) : 26'sd0)
                            + (dir_two_reg[0] ? 26'(tq) : 26'sd0)));
                        acc_r_reg <= 18'(sat16(26'(acc_r_reg)
                            + (dir_one_reg[1] ? 26'(t1_reg) : 26'sd0)
                            + (dir_two_reg[1] ? 26'(tq) : 26'sd0)));
                        voice_reg <= voice_reg + 1'b1;
                    end
                end
                ST_MIX:
                begin
                    res_reg    <= 1'b1;
                    out_rd_reg <= '0;
                    left_reg   <= acc_l_reg[15:0];
                    right_reg  <= acc_r_reg[15:0];
                end
                default: ;
            endcase
        end
    end

    // Host read: remember whether the address falls in the register file.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            address_lt_reg <= (address < KEY_ADDR);
        end
    end

    // Capture the voice's register words as the read port walks them.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LDA || state_reg == ST_LDB)
        begin
            case (4'(ridx_reg - 4'd1))
                4'd2:  r2  <= rdat_reg;
                4'd3:  r3  <= rdat_reg;
                4'd5:  r5  <= rdat_reg;
                4'd6:  r6  <= rdat_reg;
                4'd7:  r7  <= rdat_reg;
                4'd9:  r9  <= rdat_reg;
                4'd10: r10 <= rdat_reg;
                4'd11: r11 <= rdat_reg;
                4'd14: r14 <= rdat_reg;
                4'd15: r15 <= rdat_reg;
                default: ;
            endcase
        end
    end

    assign result_valid = res_reg;
    assign read_data    = out_rd_reg;
    assign left_sample  = left_reg;
    assign right_sample = right_reg;

endmodule

### rtl/core/mvpcm_mul.sv
// ----------------------------------------------------------------------------
// mvpcm_mul
// Shared signed multiplier with a registered product, used by the voice
// sequencer for the pitch step, the volume scale and the route gains.
// ----------------------------------------------------------------------------
module mvpcm_mul
    import mvpcm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  mul_req_t           req,
    output logic               done,
    output logic signed [42:0] product
);

    logic               done_reg;
    logic signed [42:0] product_reg;

    // Product register.
    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            product_reg <= 43'(req.a) * 43'(req.b);
        end
    end

    // Completion strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= req.valid;
        end
    end

    assign done    = done_reg;
    assign product = product_reg;

endmodule
